FILE: rtl/c16f_pkg.sv
package c16f_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam int          FRAME_OVERHEAD = 6;
  localparam int          Q_DEPTH        = 4;
  localparam int          Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int          Q_CNT_W        = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_HDR,
    OP_DATA,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  byte_val;
    logic [15:0] len;
    logic        last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_B0,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_B5
  } step_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/c16f_front.sv
module c16f_front #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          kind,
  input  logic [7:0]    query_code,
  input  logic [15:0]   payload_length,
  input  logic [7:0]    data_byte,
  output c16f_pkg::cmd_t cmd
);
  import c16f_pkg::*;

  localparam logic [16:0] LIMIT = 17'(MAX_FRAME_BYTES - FRAME_OVERHEAD);

  logic        frame_open, frame_open_next;
  logic [15:0] bytes_left, bytes_left_next;

  always_comb begin
    frame_open_next = frame_open;
    bytes_left_next = bytes_left;
    cmd.op       = OP_ERR;
    cmd.byte_val = data_byte;
    cmd.len      = payload_length;
    cmd.last     = 1'b0;
    if (!kind) begin
      cmd.byte_val    = query_code;
      frame_open_next = 1'b0;
      bytes_left_next = '0;
      if ({1'b0, payload_length} <= LIMIT) begin
        cmd.op          = OP_HDR;
        frame_open_next = (payload_length != '0);
        bytes_left_next = payload_length;
      end
    end else if (frame_open && bytes_left != '0) begin
      cmd.op          = OP_DATA;
      cmd.last        = (bytes_left == 16'd1);
      bytes_left_next = bytes_left - 16'd1;
      if (cmd.last) frame_open_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= '0;
    end else if (accept) begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

FILE: rtl/c16f_queue.sv
module c16f_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  c16f_pkg::cmd_t wdata,
  input  logic           pop,
  output logic           empty,
  output c16f_pkg::cmd_t rdata
);
  import c16f_pkg::*;

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr, rptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push, do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/c16f_back.sv
module c16f_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     start_byte,
  input  logic           cmd_valid,
  input  c16f_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           run_end,
  output logic           frame_end,
  output logic           error
);
  import c16f_pkg::*;

  step_t       step, step_next;
  logic [15:0] crc, crc_next, crc_seed;
  logic        ovld;
  logic        advance;
  logic [7:0]  b;
  logic        b_last, b_fe, b_err, b_upd, b_clr;

  assign empty   = !ovld;
  assign advance = cmd_valid && (!ovld || pop);
  assign cmd_pop = advance && b_last;

  always_comb begin
    b      = '0;
    b_last = 1'b0;
    b_fe   = 1'b0;
    b_err  = 1'b0;
    b_upd  = 1'b0;
    b_clr  = 1'b0;
    unique case (cmd.op)
      OP_HDR: begin
        case (step)
          ST_B0: begin b = start_byte; b_upd = 1'b1; end
          ST_B1: begin b = cmd.byte_val; b_upd = 1'b1; end
          ST_B2: begin b = cmd.len[7:0]; b_upd = 1'b1; end
          ST_B3: begin
            b      = cmd.len[15:8];
            b_upd  = 1'b1;
            b_last = (cmd.len != '0);
          end
          ST_B4: b = crc[7:0];
          default: begin
            b      = crc[15:8];
            b_fe   = 1'b1;
            b_last = 1'b1;
            b_clr  = 1'b1;
          end
        endcase
      end
      OP_DATA: begin
        case (step)
          ST_B0: begin
            b      = cmd.byte_val;
            b_upd  = 1'b1;
            b_last = !cmd.last;
          end
          ST_B1: b = crc[7:0];
          default: begin
            b      = crc[15:8];
            b_fe   = 1'b1;
            b_last = 1'b1;
            b_clr  = 1'b1;
          end
        endcase
      end
      default: begin
        b_err  = 1'b1;
        b_last = 1'b1;
        b_clr  = 1'b1;
      end
    endcase
  end

  always_comb begin
    crc_seed  = (cmd.op == OP_HDR && step == ST_B0) ? CRC_INIT : crc;
    crc_next  = crc;
    step_next = step;
    if (advance) begin
      if (b_clr) crc_next = CRC_INIT;
      else if (b_upd) crc_next = crc_byte(crc_seed, b);
      step_next = b_last ? ST_B0 : step_t'(step + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_B0;
      crc  <= CRC_INIT;
      ovld <= 1'b0;
    end else begin
      step <= step_next;
      crc  <= crc_next;
      if (advance) ovld <= 1'b1;
      else if (pop) ovld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= b;
      run_end   <= b_last;
      frame_end <= b_fe;
      error     <= b_err;
    end
  end

  a_fe_ends_run: assert property (@(posedge clk) disable iff (rst)
    ovld && frame_end |-> run_end && !error)
    else $error("frame end without run end");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    ovld && error |-> run_end && out_byte == 8'h00)
    else $error("malformed error item");

  a_crc_reset: assert property (@(posedge clk) disable iff (rst)
    advance && b_clr |=> crc == CRC_INIT)
    else $error("crc not reinitialized");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovld && !pop |=> ovld && $stable(out_byte) && $stable(run_end))
    else $error("result changed while stalled");

endmodule

FILE: rtl/crc16_packet_framer.sv
// CRC-16 packet framer.
// Input channel (push/full): header items (kind 0) carry query_code and
// payload_length; payload items (kind 1) carry data_byte. An item is taken
// when push is high and full is low.
// Result channel (empty/pop): one frame byte per item, oldest first.
// A header gives start byte, query code, length low, length high, plus the
// two CRC bytes when the length is zero. A payload byte gives itself, plus
// the CRC low/high bytes when it is the last one. Bad items give one error
// result. run_end marks the last result of an input item.
// cfg_we/cfg_wdata write the start byte; write only while the block is idle.
// The first result of an item passes the command queue and the output
// register before it shows on the ports. The output sequencer gives one
// result per cycle while commands wait and pop keeps up, so payload bytes
// stream at one per cycle. A 4-entry command queue decouples the input side.
// Reset clears the queue, the open-frame tracking and the start byte.
// When pop stays low the result holds, the queue fills and full rises.
module crc16_packet_framer #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  query_code,
  input  logic [15:0] payload_length,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_end,
  output logic        frame_end,
  output logic        error
);
  import c16f_pkg::*;

  logic [7:0] start_byte;
  cmd_t       f_cmd, q_cmd;
  logic       q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) start_byte <= '0;
    else if (cfg_we) start_byte <= cfg_wdata;
  end

  c16f_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (push && !full),
    .kind          (kind),
    .query_code    (query_code),
    .payload_length(payload_length),
    .data_byte     (data_byte),
    .cmd           (f_cmd)
  );

  c16f_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .wdata(f_cmd),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_cmd)
  );

  c16f_back u_back (
    .clk       (clk),
    .rst       (rst),
    .start_byte(start_byte),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .frame_end (frame_end),
    .error     (error)
  );

endmodule

FILE: dv/crc16_packet_framer_tb.sv
`timescale 1ns / 1ps

module crc16_packet_framer_tb;
  import c16f_pkg::*;

  localparam int          MAX_FRAME_BYTES = 256;
  localparam int          LEN_LIMIT       = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int          LIMIT_CYCLES    = 200000;
  localparam logic        KIND_HDR        = 1'b0;
  localparam logic        KIND_DATA       = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       frame_end;
    logic       err;
  } frame_byte_t;

  class framer_scoreboard;
    logic [7:0]  start_byte;
    logic [15:0] crc;
    logic [15:0] bytes_left;
    bit          open;
    frame_byte_t exp_q[$];
    int          errors;

    function new();
      start_byte = 8'h00;
      crc        = CRC_INIT;
      bytes_left = 16'd0;
      open       = 1'b0;
      errors     = 0;
    endfunction

    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        if (r[15] ^ b[i]) r = {r[14:0], 1'b0} ^ CRC_POLY;
        else r = {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void add(logic [7:0] b, logic fe, logic er);
      frame_byte_t e;
      e.value     = b;
      e.run_end   = 1'b0;
      e.frame_end = fe;
      e.err       = er;
      exp_q.push_back(e);
    endfunction

    function void add_data(logic [7:0] b);
      crc = crc_next(crc, b);
      add(b, 1'b0, 1'b0);
    endfunction

    function void close_frame();
      add(crc[7:0], 1'b0, 1'b0);
      add(crc[15:8], 1'b1, 1'b0);
      crc        = CRC_INIT;
      open       = 1'b0;
      bytes_left = 16'd0;
    endfunction

    function void note_item(logic k, logic [7:0] q, logic [15:0] len, logic [7:0] d);
      frame_byte_t t;
      if (k == KIND_HDR) begin
        crc        = CRC_INIT;
        open       = 1'b0;
        bytes_left = 16'd0;
        if (len > LEN_LIMIT) begin
          add(8'h00, 1'b0, 1'b1);
        end else begin
          add_data(start_byte);
          add_data(q);
          add_data(len[7:0]);
          add_data(len[15:8]);
          if (len == 16'd0) begin
            close_frame();
          end else begin
            open       = 1'b1;
            bytes_left = len;
          end
        end
      end else begin
        if (!open || bytes_left == 16'd0) begin
          add(8'h00, 1'b0, 1'b1);
        end else begin
          add_data(d);
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) close_frame();
        end
      end
      t = exp_q.pop_back();
      t.run_end = 1'b1;
      exp_q.push_back(t);
    endfunction

    function void check_result(logic [7:0] b, logic re, logic fe, logic er);
      frame_byte_t e;
      if (exp_q.size() == 0) begin
        $error("unexpected item: out_byte %0h run_end %0b frame_end %0b error %0b",
               b, re, fe, er);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      if (b !== e.value) begin
        $error("out_byte: expected %0h, got %0h", e.value, b);
        errors++;
      end
      if (re !== e.run_end) begin
        $error("run_end: expected %0b, got %0b", e.run_end, re);
        errors++;
      end
      if (fe !== e.frame_end) begin
        $error("frame_end: expected %0b, got %0b", e.frame_end, fe);
        errors++;
      end
      if (er !== e.err) begin
        $error("error: expected %0b, got %0b", e.err, er);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        push;
  logic        full;
  logic        kind;
  logic [7:0]  query_code;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        run_end;
  logic        frame_end;
  logic        error;

  framer_scoreboard sb;
  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int cycles = 0;

  crc16_packet_framer #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .query_code     (query_code),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .run_end        (run_end),
    .frame_end      (frame_end),
    .error          (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic drive_item(logic k, logic [7:0] q, logic [15:0] len, logic [7:0] d);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    kind           <= k;
    query_code     <= q;
    payload_length <= len;
    data_byte      <= d;
    do @(posedge clk); while (full);
    sb.note_item(k, q, len, d);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_start(logic [7:0] v);
    push      <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.start_byte = v;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic directed_items();
    drive_item(KIND_DATA, 8'h00, 16'h0000, 8'hFF);    // payload, nothing open
    drive_item(KIND_HDR, 8'h00, 16'd0, 8'hFF);        // empty payload
    drive_item(KIND_HDR, 8'hFF, 16'(LEN_LIMIT), 8'h00); // largest legal length
    drive_item(KIND_DATA, 8'hFF, 16'hFFFF, 8'h00);
    drive_item(KIND_DATA, 8'h00, 16'h0000, 8'hFF);
    drive_item(KIND_HDR, 8'h5A, 16'd1, 8'h00);        // abandons open packet
    drive_item(KIND_DATA, 8'hA5, 16'h1234, 8'h80);
    drive_item(KIND_DATA, 8'h00, 16'h0000, 8'h01);    // frame already closed
    drive_item(KIND_HDR, 8'h01, 16'(LEN_LIMIT + 1), 8'h00);
    drive_item(KIND_HDR, 8'hFF, 16'hFFFF, 8'hFF);
    drive_item(KIND_HDR, 8'h80, 16'h8000, 8'h7F);
    drive_item(KIND_HDR, 8'h3C, 16'd3, 8'hFF);
    drive_item(KIND_DATA, 8'hFF, 16'hFFFF, 8'h11);
    drive_item(KIND_HDR, 8'hC3, 16'd2, 8'h00);
    drive_item(KIND_DATA, 8'h00, 16'h0000, 8'h22);
    drive_item(KIND_DATA, 8'hFF, 16'h5555, 8'h33);
    drive_item(KIND_HDR, 8'h42, 16'd4, 8'hAA);
    drive_item(KIND_DATA, 8'h00, 16'hAAAA, 8'h55);
    drive_item(KIND_HDR, 8'h24, 16'd300, 8'h00);      // oversize closes open packet
    drive_item(KIND_DATA, 8'h00, 16'h0000, 8'h44);
    drive_item(KIND_HDR, 8'h7E, 16'h0100, 8'h00);
    drive_item(KIND_HDR, 8'h81, 16'd1, 8'h00);
    drive_item(KIND_DATA, 8'h00, 16'h0000, 8'h00);
  endtask

  task automatic random_traffic(int n);
    int stop_at;
    int r;
    int len;
    int cut;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 6);
        else if (r < 95) len = $urandom_range(7, 24);
        else if (r < 99) len = $urandom_range(25, LEN_LIMIT - 1);
        else len = LEN_LIMIT;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
        drive_item(KIND_HDR, 8'($urandom), 16'(len), 8'($urandom));
        for (int i = 0; i < cut && items_sent < stop_at; i++)
          drive_item(KIND_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (r < 85) begin
        drive_item(KIND_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (r < 95) begin
        drive_item(KIND_HDR, 8'($urandom), 16'($urandom_range(LEN_LIMIT + 1, 65535)),
                   8'($urandom));
      end else begin
        drive_item(KIND_HDR, 8'($urandom), 16'($urandom_range(1, LEN_LIMIT)),
                   8'($urandom));
      end
    end
  endtask

  // result side
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= !gaps_on || $urandom_range(0, 99) >= 23;
      end
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_result(out_byte, run_end, frame_end, error);
    end
  end

  initial begin
    sb             = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = 8'h00;
    push           = 1'b0;
    kind           = KIND_HDR;
    query_code     = 8'h00;
    payload_length = 16'h0000;
    data_byte      = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_start(8'hFF);
    directed_items();
    drain();

    write_start(8'h00);
    hold_req = 1'b1;
    random_traffic(50);
    drain();

    gaps_on = 1'b0;
    write_start(8'($urandom));
    random_traffic(50);
    drain();

    gaps_on = 1'b1;
    write_start(8'($urandom_range(1, 254)));
    random_traffic(50);
    drain();

    write_start(8'($urandom));
    random_traffic(50);
    drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
